// ===== rtl/core/mebe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mebe_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int GROUP_W  = 7;
    localparam int GROUPS   = 5;
    localparam int VLQ_W    = GROUP_W * GROUPS;
    localparam int CNT_W    = 3;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam action_t ACT_DELTA       = 2'd0;
    localparam action_t ACT_MESSAGE     = 2'd1;
    localparam action_t ACT_TRACK_START = 2'd2;

    localparam byte_t META_START    = 8'hFF;
    localparam byte_t SYSEX_START   = 8'hF0;
    localparam byte_t SYSEX_ESCAPE  = 8'hF7;
    localparam byte_t STATUS_BIT    = 8'h80;
    localparam byte_t GROUP_MASK    = 8'h7F;
    localparam byte_t SYSTEM_NIBBLE = 8'hF0;

    localparam cnt_t GROUP_COUNT = cnt_t'(GROUPS);
    localparam cnt_t CNT_LAST    = cnt_t'(1);

    typedef struct packed {
        logic  busy;
        logic  avail;
        byte_t data;
        logic  last;
    } vlq_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mebe_vlq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mebe_vlq (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        load,
    input  wire [mebe_pkg::VALUE_W-1:0] ticks,
    input  wire                        advance,
    output mebe_pkg::vlq_status_t      status
);
    import mebe_pkg::*;

    logic [VLQ_W-1:0]   sreg_reg;
    logic [VLQ_W-1:0]   sreg_next;
    cnt_t               cnt_reg;
    cnt_t               cnt_next;
    logic               emit_reg;
    logic               emit_next;
    logic [GROUP_W-1:0] top_group;
    logic               busy;
    logic               avail;

    assign top_group = sreg_reg[VLQ_W-1 -: GROUP_W];
    assign busy      = (cnt_reg != '0);
    assign avail     = busy && (emit_reg || (top_group != '0) || (cnt_reg == CNT_LAST));

    always_comb
    begin
        status.busy  = busy;
        status.avail = avail;
        status.last  = (cnt_reg == CNT_LAST);
        status.data  = ({1'b0, top_group} & GROUP_MASK)
                     | ((cnt_reg != CNT_LAST) ? STATUS_BIT : '0);
    end

    // shared 7-bit shifter: skips leading zero groups, then emits one group per step
    always_comb
    begin
        sreg_next = sreg_reg;
        cnt_next  = cnt_reg;
        emit_next = emit_reg;
        if (load)
        begin
            sreg_next = {{(VLQ_W-VALUE_W){1'b0}}, ticks};
            cnt_next  = GROUP_COUNT;
            emit_next = 1'b0;
        end
        else if (busy && (!avail || advance))
        begin
            sreg_next = {sreg_reg[VLQ_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
            cnt_next  = cnt_reg - CNT_LAST;
            emit_next = emit_reg | avail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            emit_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            emit_reg <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sreg_reg <= sreg_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/mebe_status.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mebe_status (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire                cfg_data,
    input  wire                update,
    input  mebe_pkg::action_t  action,
    input  mebe_pkg::byte_t    msg_byte,
    input  wire                first,
    output logic               emit
);
    import mebe_pkg::*;

    byte_t rem_reg;
    byte_t rem_next;
    logic  enable_reg;
    logic  is_status;
    logic  is_special;
    logic  drop;

    assign is_status  = (msg_byte & STATUS_BIT) != '0;
    assign is_special = (msg_byte == META_START) || (msg_byte == SYSEX_START)
                     || (msg_byte == SYSEX_ESCAPE);
    assign drop = first && is_status && !is_special && enable_reg
               && (msg_byte == rem_reg)
               && ((msg_byte & SYSTEM_NIBBLE) != SYSTEM_NIBBLE);
    assign emit = !drop;

    always_comb
    begin
        rem_next = rem_reg;
        if (update)
        begin
            case (action)
                ACT_TRACK_START:
                begin
                    rem_next = '0;
                end
                ACT_MESSAGE:
                begin
                    if (first && is_special)
                        rem_next = '0;
                    else if (first && is_status && !drop)
                        rem_next = msg_byte;
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            enable_reg <= 1'b1;
        end
        else
        begin
            rem_reg <= rem_next;
            if (cfg_we)
                enable_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/midi_event_byte_encoder.sv =====
// midi track event byte encoder
// input channel: item_valid / item_ready with action, value, first_of_message.
//   action 0 encodes value as a variable-length delta (1 to 5 bytes, msb group first),
//   action 1 passes the low byte of value as a message byte unless it repeats the
//   remembered running status, action 2 clears that status, action 3 is ignored.
// output channel: byte_valid / byte_ready with out_byte and last; last marks
//   the final byte produced by one input transaction.
// configuration: cfg_we writes cfg_data into the running status enable (reset 1).
// a message byte is registered and appears in the cycle after its input
//   transaction; a delta is loaded into the shared 7-bit group shifter, which
//   skips leading zero groups and then emits the rest msb first, one per cycle
//   while the receiver takes them. a message byte or track start leaves the
//   input free for the next item; a delta holds it until the shifter is done.
// item_ready is low while a delta is being encoded and while the output
//   register holds a byte that is not taken in this cycle.
// when the receiver stalls, out_byte and last hold until byte_ready is seen;
//   the shifter waits on its current group.
// reset clears the output valid flag, the shifter count and the remembered status and
//   sets running status enable.
`timescale 1ns / 1ps
`default_nettype none

module midi_event_byte_encoder (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire                         cfg_data,
    input  wire                         item_valid,
    output logic                        item_ready,
    input  wire [mebe_pkg::ACTION_W-1:0] action,
    input  wire [mebe_pkg::VALUE_W-1:0]  value,
    input  wire                         first_of_message,
    output logic                        byte_valid,
    input  wire                         byte_ready,
    output logic [mebe_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last
);
    import mebe_pkg::*;

    vlq_status_t vlq_st;
    logic        slot_free;
    logic        item_accept;
    logic        delta_load;
    logic        msg_emit;
    logic        vlq_advance;
    logic        emit;
    byte_t       msg_byte;

    logic        valid_reg;
    logic        valid_next;
    byte_t       byte_reg;
    byte_t       byte_next;
    logic        last_reg;
    logic        last_next;

    assign msg_byte    = value[BYTE_W-1:0];
    assign slot_free   = !valid_reg || byte_ready;
    assign item_ready  = slot_free && !vlq_st.busy;
    assign item_accept = item_valid && item_ready;
    assign delta_load  = item_accept && (action == ACT_DELTA);
    assign msg_emit    = item_accept && (action == ACT_MESSAGE) && emit;
    assign vlq_advance = slot_free && vlq_st.avail;

    mebe_vlq u_vlq (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (delta_load),
        .ticks   (value),
        .advance (vlq_advance),
        .status  (vlq_st)
    );

    mebe_status u_status (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .update   (item_accept),
        .action   (action_t'(action)),
        .msg_byte (msg_byte),
        .first    (first_of_message),
        .emit     (emit)
    );

    always_comb
    begin
        valid_next = valid_reg && !byte_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (vlq_advance)
        begin
            valid_next = 1'b1;
            byte_next  = vlq_st.data;
            last_next  = vlq_st.last;
        end
        else if (msg_emit)
        begin
            valid_next = 1'b1;
            byte_next  = msg_byte;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign byte_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mebe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mebe_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          item_valid,
    input wire                          item_ready,
    input wire [mebe_pkg::ACTION_W-1:0] action,
    input wire [mebe_pkg::VALUE_W-1:0]  value,
    input wire                          first_of_message,
    input wire                          byte_valid,
    input wire                          byte_ready,
    input wire [mebe_pkg::BYTE_W-1:0]   out_byte,
    input wire                          last
);
    import mebe_pkg::*;

    // stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(out_byte) && $stable(last))
        else $error("output changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |-> !item_ready)
        else $error("input taken while output stalled");

    // a non-first message byte passes straight through
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (action == ACT_MESSAGE) && !first_of_message
        |=> byte_valid && last && (out_byte == $past(value[BYTE_W-1:0])))
        else $error("message byte not passed through");

    // a delta occupies the shifter for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (action == ACT_DELTA) |=> !item_ready)
        else $error("input taken during delta encoding");

endmodule

bind midi_event_byte_encoder mebe_checker u_mebe_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .action           (action),
    .value            (value),
    .first_of_message (first_of_message),
    .byte_valid       (byte_valid),
    .byte_ready       (byte_ready),
    .out_byte         (out_byte),
    .last             (last)
);

`default_nettype wire
